// ----- rtl/core/usbce_pkg.sv -----
// Package for the USB control endpoint engine: payload structs, opcodes,
// result kinds, request codes and sequencer states. No dependencies.
package usbce_pkg;

    typedef enum logic [2:0] {
        OP_SETUP       = 3'd0,
        OP_IN_READY    = 3'd1,
        OP_OUT_DATA    = 3'd2,
        OP_BUS_RESET   = 3'd3,
        OP_LOAD_ROM    = 3'd4,
        OP_LOAD_MAP    = 3'd5,
        OP_LOAD_SERIAL = 3'd6,
        OP_UNUSED      = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        K_DATA     = 3'd0,
        K_COMMIT   = 3'd1,
        K_STALL    = 3'd2,
        K_SET_ADDR = 3'd3,
        K_ADDR_EN  = 3'd4,
        K_CONFIG   = 3'd5,
        K_BOOT     = 3'd6,
        K_OUT_ACK  = 3'd7
    } kind_t;

    localparam logic [15:0] REQ_NONE        = 16'h0000;
    localparam logic [15:0] REQ_GET_STATUS  = 16'h8000;
    localparam logic [15:0] REQ_SET_ADDRESS = 16'h0005;
    localparam logic [15:0] REQ_GET_DESC    = 16'h8006;
    localparam logic [15:0] REQ_SET_CONFIG  = 16'h0009;
    localparam logic [15:0] REQ_SET_LINE    = 16'h2120;
    localparam logic [15:0] REQ_GET_LINE    = 16'hA121;
    localparam logic [15:0] REQ_SET_CTRL    = 16'h2122;
    localparam logic [15:0] REQ_BOOT        = 16'h4001;
    localparam logic [15:0] SERIAL_KEY      = 16'h0302;
    localparam logic [31:0] BOOT_RATE       = 32'h337A7E74;
    localparam logic [31:0] DEFAULT_RATE    = 32'd1234;

    localparam logic CFG_SERIAL_LENGTH = 1'b0;
    localparam logic CFG_MAP_COUNT     = 1'b1;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] setup_value;
        logic [15:0] setup_index;
        logic [15:0] setup_length;
        logic [31:0] out_rate;
        logic [9:0]  load_address;
        logic [7:0]  load_byte;
        logic [15:0] map_key;
        logic [9:0]  map_first;
        logic [9:0]  map_end;
    } in_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic [6:0] device_address;
        logic       boot_enable;
        logic       last;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_SEARCH_WAIT,
        S_LIST,
        S_STR,
        S_STR_WAIT,
        S_ROM,
        S_ROM_WAIT,
        S_EMIT
    } state_t;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        hex_char = (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h57 + {4'h0, v});
    endfunction

endpackage

// ----- rtl/core/usbce_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module usbce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/usb_control_endpoint_engine.sv -----
// USB control endpoint engine top level: event sequencer and stores.
// Depends on usbce_pkg and usbce_ram.
//
// Usage: one input channel (in_valid/in_ready/in_data) carries events and
// store loads; one output channel (out_valid/out_ready/out_data) carries
// result items, the final one of each event marked by last. The config
// channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes serial_length and
// map_count and is always ready.
// One event is handled at a time. A load, a bus reset or an event without
// results returns to idle straight from decode. An event answered from a
// short result list emits the list entries in order. A descriptor lookup
// examines the key map entries one at a time and emits a stall when no key
// matches. An IN event reads each data byte through the one memory read port
// of its store.
// When the receiver stalls, the current result holds in the output
// register and the sequencer waits. Reset aborts any request, sets the
// line rate to 1234, sets the boot flag and clears the other control
// registers; the item, list and store contents stay undefined until loaded.
module usb_control_endpoint_engine
    import usbce_pkg::*;
#(
    parameter int ROM_BYTES    = 1024,
    parameter int MAP_ENTRIES  = 16,
    parameter int PACKET_BYTES = 32,
    parameter int SERIAL_BYTES = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_index,
    input  logic [4:0] cfg_data
);

    localparam int RAW = $clog2(ROM_BYTES);
    localparam int MAW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int MDP = (MAP_ENTRIES > 1) ? MAP_ENTRIES : 2;
    localparam int SAW = (SERIAL_BYTES > 1) ? $clog2(SERIAL_BYTES) : 1;
    localparam int SDP = (SERIAL_BYTES > 1) ? SERIAL_BYTES : 2;
    localparam int PKW = $clog2(PACKET_BYTES);
    localparam logic [4:0] SER_MAX = 5'(SERIAL_BYTES);
    localparam logic [4:0] MAP_MAX = 5'(MAP_ENTRIES);

    state_t state_reg, state_next;
    in_item_t item_reg, item_next;
    logic [4:0] serial_length_reg, map_count_reg;
    logic [15:0] active_request_reg, active_request_next;
    logic [15:0] latched_value_reg, latched_value_next;
    logic [15:0] latched_length_reg, latched_length_next;
    logic [7:0] string_pos_reg, string_pos_next;
    logic [7:0] string_len_reg, string_len_next;
    logic [9:0] rom_cursor_reg, rom_cursor_next;
    logic [9:0] rom_end_reg, rom_end_next;
    logic [31:0] line_rate_reg, line_rate_next;
    logic boot_flag_reg, boot_flag_next;
    logic [4:0] idx_reg, idx_next;
    logic [6:0] left_reg, left_next;
    logic [3:0] list_pos_reg, list_pos_next;
    logic [3:0] list_len_reg, list_len_next;
    logic [7:0] list_data [8];
    logic [2:0] list_kind [8];
    logic [2:0] lk_next [8];
    logic [7:0] ld_next [8];
    logic out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    logic rom_we, map_we, ser_we;
    logic [RAW-1:0] rom_raddr;
    logic [7:0] rom_rdata;
    logic [MAW-1:0] map_raddr;
    logic [35:0] map_rdata;
    logic [SAW-1:0] ser_raddr;
    logic [7:0] ser_rdata;

    logic [4:0] sl_eff, mc_eff;
    logic [7:0] p2;
    logic [15:0] setup_req;

    assign rom_we = state_reg == S_DECODE && item_reg.opcode == OP_LOAD_ROM
                    && {6'd0, item_reg.load_address} < 16'(ROM_BYTES);
    assign map_we = state_reg == S_DECODE && item_reg.opcode == OP_LOAD_MAP
                    && {6'd0, item_reg.load_address} < 16'(MAP_ENTRIES);
    assign ser_we = state_reg == S_DECODE && item_reg.opcode == OP_LOAD_SERIAL
                    && {6'd0, item_reg.load_address} < 16'(SERIAL_BYTES);

    usbce_ram #(.WIDTH(8), .DEPTH(ROM_BYTES)) u_rom (
        .clk(clk), .we(rom_we), .waddr(item_reg.load_address[RAW-1:0]),
        .wdata(item_reg.load_byte), .raddr(rom_raddr), .rdata(rom_rdata)
    );

    usbce_ram #(.WIDTH(36), .DEPTH(MDP)) u_map (
        .clk(clk), .we(map_we), .waddr(item_reg.load_address[MAW-1:0]),
        .wdata({item_reg.map_key, item_reg.map_first, item_reg.map_end}),
        .raddr(map_raddr), .rdata(map_rdata)
    );

    usbce_ram #(.WIDTH(8), .DEPTH(SDP)) u_ser (
        .clk(clk), .we(ser_we), .waddr(item_reg.load_address[SAW-1:0]),
        .wdata(item_reg.load_byte), .raddr(ser_raddr), .rdata(ser_rdata)
    );

    assign sl_eff = (serial_length_reg > SER_MAX) ? SER_MAX : serial_length_reg;
    assign mc_eff = (map_count_reg > MAP_MAX) ? MAP_MAX : map_count_reg;
    assign p2 = string_pos_reg - 8'd2;
    assign setup_req = {item_reg.request_type, item_reg.request_code};
    assign rom_raddr = rom_cursor_reg[RAW-1:0];
    assign map_raddr = idx_reg[MAW-1:0];
    assign ser_raddr = p2[SAW+1:2];

    assign in_ready = state_reg == S_IDLE && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            serial_length_reg <= '0;
            map_count_reg <= '0;
            active_request_reg <= REQ_NONE;
            latched_value_reg <= '0;
            latched_length_reg <= '0;
            string_pos_reg <= '0;
            string_len_reg <= '0;
            rom_cursor_reg <= '0;
            rom_end_reg <= '0;
            line_rate_reg <= DEFAULT_RATE;
            boot_flag_reg <= 1'b1;
            out_valid_reg <= 1'b0;
            idx_reg <= '0;
            left_reg <= '0;
            list_pos_reg <= '0;
            list_len_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                if (cfg_index == CFG_SERIAL_LENGTH)
                begin
                    serial_length_reg <= cfg_data;
                end
                else
                begin
                    map_count_reg <= cfg_data;
                end
            end
            active_request_reg <= active_request_next;
            latched_value_reg <= latched_value_next;
            latched_length_reg <= latched_length_next;
            string_pos_reg <= string_pos_next;
            string_len_reg <= string_len_next;
            rom_cursor_reg <= rom_cursor_next;
            rom_end_reg <= rom_end_next;
            line_rate_reg <= line_rate_next;
            boot_flag_reg <= boot_flag_next;
            out_valid_reg <= out_valid_next;
            idx_reg <= idx_next;
            left_reg <= left_next;
            list_pos_reg <= list_pos_next;
            list_len_reg <= list_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_reg <= out_next;
        for (int i = 0; i < 8; i++)
        begin
            list_kind[i] <= lk_next[i];
            list_data[i] <= ld_next[i];
        end
    end

    // The output register is loaded only when empty or being drained.
    always_comb
    begin
        logic can_emit;
        logic [7:0] sbyte;
        state_next = state_reg;
        item_next = item_reg;
        active_request_next = active_request_reg;
        latched_value_next = latched_value_reg;
        latched_length_next = latched_length_reg;
        string_pos_next = string_pos_reg;
        string_len_next = string_len_reg;
        rom_cursor_next = rom_cursor_reg;
        rom_end_next = rom_end_reg;
        line_rate_next = line_rate_reg;
        boot_flag_next = boot_flag_reg;
        idx_next = idx_reg;
        left_next = left_reg;
        list_pos_next = list_pos_reg;
        list_len_next = list_len_reg;
        out_next = out_reg;
        lk_next = list_kind;
        ld_next = list_data;
        can_emit = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg && !out_ready;
        sbyte = p2[0] ? 8'd0 : hex_char(p2[1] ? ser_rdata[3:0] : ser_rdata[7:4]);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    item_next = in_data;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                list_pos_next = '0;
                list_len_next = '0;
                state_next = S_IDLE;
                for (int i = 0; i < 8; i++)
                begin
                    lk_next[i] = K_DATA;
                    ld_next[i] = 8'd0;
                end
                unique case (opcode_t'(item_reg.opcode))
                    OP_SETUP:
                    begin
                        active_request_next = setup_req;
                        latched_value_next = item_reg.setup_value;
                        latched_length_next = item_reg.setup_length;
                        state_next = S_LIST;
                        unique case (setup_req)
                            REQ_GET_STATUS:
                            begin
                                lk_next[2] = K_COMMIT;
                                list_len_next = 4'd3;
                            end
                            REQ_SET_ADDRESS:
                            begin
                                lk_next[0] = K_SET_ADDR;
                                ld_next[0] = {1'b0, item_reg.setup_value[6:0]};
                                lk_next[1] = K_COMMIT;
                                list_len_next = 4'd2;
                            end
                            REQ_GET_DESC:
                            begin
                                if (item_reg.setup_value == SERIAL_KEY)
                                begin
                                    string_pos_next = 8'd2;
                                    string_len_next = {1'b0, sl_eff, 2'b10};
                                    if (item_reg.setup_length < {9'd0, sl_eff, 2'b10})
                                    begin
                                        string_len_next = item_reg.setup_length[7:0];
                                    end
                                    ld_next[0] = {1'b0, sl_eff, 2'b10};
                                    ld_next[1] = 8'd3;
                                    list_len_next = 4'd2;
                                end
                                else
                                begin
                                    idx_next = '0;
                                    state_next = S_SEARCH;
                                end
                            end
                            REQ_SET_CONFIG:
                            begin
                                lk_next[0] = K_CONFIG;
                                lk_next[1] = K_COMMIT;
                                list_len_next = 4'd2;
                            end
                            REQ_SET_LINE:
                            begin
                                state_next = S_IDLE;
                            end
                            REQ_GET_LINE:
                            begin
                                ld_next[0] = line_rate_reg[7:0];
                                ld_next[1] = line_rate_reg[15:8];
                                ld_next[2] = line_rate_reg[23:16];
                                ld_next[3] = line_rate_reg[31:24];
                                ld_next[6] = 8'd8;
                                lk_next[7] = K_COMMIT;
                                list_len_next = 4'd8;
                            end
                            REQ_SET_CTRL:
                            begin
                                lk_next[0] = K_COMMIT;
                                list_len_next = 4'd1;
                            end
                            REQ_BOOT:
                            begin
                                lk_next[0] = K_BOOT;
                                list_len_next = 4'd1;
                            end
                            default:
                            begin
                                lk_next[0] = K_STALL;
                                list_len_next = 4'd1;
                                active_request_next = REQ_NONE;
                            end
                        endcase
                    end
                    OP_IN_READY:
                    begin
                        if (active_request_reg == REQ_GET_DESC)
                        begin
                            if (latched_value_reg == SERIAL_KEY)
                            begin
                                left_next = 7'(PACKET_BYTES)
                                    - {1'b0, 6'(string_pos_reg[PKW-1:0])};
                                state_next = S_STR;
                            end
                            else
                            begin
                                left_next = 7'(PACKET_BYTES);
                                state_next = S_ROM;
                            end
                        end
                        else if (active_request_reg == REQ_SET_ADDRESS)
                        begin
                            lk_next[0] = K_ADDR_EN;
                            list_len_next = 4'd1;
                            active_request_next = REQ_NONE;
                            state_next = S_LIST;
                        end
                        else if (active_request_reg != REQ_SET_LINE)
                        begin
                            active_request_next = REQ_NONE;
                        end
                    end
                    OP_OUT_DATA:
                    begin
                        state_next = S_LIST;
                        if (active_request_reg == REQ_SET_LINE)
                        begin
                            line_rate_next = item_reg.out_rate;
                            boot_flag_next = item_reg.out_rate == DEFAULT_RATE;
                            active_request_next = REQ_NONE;
                            if (item_reg.out_rate == BOOT_RATE)
                            begin
                                lk_next[0] = K_BOOT;
                                lk_next[1] = K_OUT_ACK;
                                lk_next[2] = K_COMMIT;
                                list_len_next = 4'd3;
                            end
                            else
                            begin
                                lk_next[0] = K_OUT_ACK;
                                lk_next[1] = K_COMMIT;
                                list_len_next = 4'd2;
                            end
                        end
                        else
                        begin
                            lk_next[0] = K_OUT_ACK;
                            list_len_next = 4'd1;
                        end
                    end
                    OP_BUS_RESET:
                    begin
                        active_request_next = REQ_NONE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SEARCH:
            begin
                if (idx_reg >= mc_eff)
                begin
                    lk_next[0] = K_STALL;
                    list_len_next = 4'd1;
                    active_request_next = REQ_NONE;
                    state_next = S_LIST;
                end
                else
                begin
                    state_next = S_SEARCH_WAIT;
                end
            end
            S_SEARCH_WAIT:
            begin
                if (map_rdata[35:20] == latched_value_reg)
                begin
                    rom_cursor_next = map_rdata[19:10];
                    rom_end_next = map_rdata[9:0];
                    if ({6'd0, map_rdata[9:0] - map_rdata[19:10]} > latched_length_reg)
                    begin
                        rom_end_next = map_rdata[19:10] + latched_length_reg[9:0];
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 5'd1;
                    state_next = S_SEARCH;
                end
            end
            S_LIST:
            begin
                if (can_emit)
                begin
                    out_next.kind = list_kind[list_pos_reg[2:0]];
                    out_next.data_byte = (list_kind[list_pos_reg[2:0]] == K_SET_ADDR)
                        ? 8'd0 : list_data[list_pos_reg[2:0]];
                    out_next.device_address =
                        (list_kind[list_pos_reg[2:0]] == K_SET_ADDR)
                        ? list_data[list_pos_reg[2:0]][6:0] : 7'd0;
                    out_next.boot_enable = boot_flag_reg;
                    out_next.last = (list_pos_reg + 4'd1 == list_len_reg);
                    out_valid_next = 1'b1;
                    list_pos_next = list_pos_reg + 4'd1;
                    if (list_pos_reg + 4'd1 == list_len_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_STR:
            begin
                if (string_pos_reg < string_len_reg && left_reg != 7'd0)
                begin
                    state_next = S_STR_WAIT;
                end
                else
                begin
                    if (left_reg != 7'd0)
                    begin
                        active_request_next = REQ_NONE;
                    end
                    state_next = S_EMIT;
                end
            end
            S_STR_WAIT:
            begin
                if (can_emit)
                begin
                    out_next = '{K_DATA, sbyte, 7'd0, boot_flag_reg, 1'b0};
                    out_valid_next = 1'b1;
                    string_pos_next = string_pos_reg + 8'd1;
                    left_next = left_reg - 7'd1;
                    state_next = S_STR;
                end
            end
            S_ROM:
            begin
                if (rom_cursor_reg != rom_end_reg && left_reg != 7'd0)
                begin
                    state_next = S_ROM_WAIT;
                end
                else
                begin
                    if (left_reg != 7'd0)
                    begin
                        active_request_next = REQ_NONE;
                    end
                    state_next = S_EMIT;
                end
            end
            S_ROM_WAIT:
            begin
                if (can_emit)
                begin
                    out_next = '{K_DATA,
                        ({6'd0, rom_cursor_reg} < 16'(ROM_BYTES)) ? rom_rdata : 8'd0,
                        7'd0, boot_flag_reg, 1'b0};
                    out_valid_next = 1'b1;
                    rom_cursor_next = rom_cursor_reg + 10'd1;
                    left_next = left_reg - 7'd1;
                    state_next = S_ROM;
                end
            end
            S_EMIT:
            begin
                if (can_emit)
                begin
                    out_next = '{K_COMMIT, 8'd0, 7'd0, boot_flag_reg, 1'b1};
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("input taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_data))
        else $error("stalled result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROM_WAIT) |-> left_reg != 7'd0)
        else $error("packet overrun");

endmodule

// ----- test/usb_control_endpoint_engine_tb.sv -----
// Testbench for usb_control_endpoint_engine: random and directed endpoint events
// are checked against a behavioral predictor held in a small scoreboard class.
// Depends on usbce_pkg and the engine RTL.
`timescale 1ns / 1ps

module testbench;
    import usbce_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    class endpoint_scoreboard;
        out_item_t   expected_q[$];
        out_item_t   batch[$];
        int          errors;
        logic [4:0]  serial_length;
        logic [4:0]  map_count;
        logic [15:0] active_req;
        logic [15:0] req_value;
        logic [15:0] req_len;
        logic [7:0]  str_pos;
        logic [7:0]  str_len;
        logic [9:0]  cursor;
        logic [9:0]  rom_stop;
        logic [31:0] rate;
        logic        boot;
        logic [7:0]  rom[1024];
        logic [15:0] map_key[16];
        logic [9:0]  map_first[16];
        logic [9:0]  map_end[16];
        logic [7:0]  serial[16];

        function new();
            errors = 0;
            serial_length = '0;
            map_count = '0;
            active_req = REQ_NONE;
            req_value = '0;
            req_len = '0;
            str_pos = '0;
            str_len = '0;
            cursor = '0;
            rom_stop = '0;
            rate = DEFAULT_RATE;
            boot = 1'b1;
        endfunction

        function void configure(logic idx, logic [4:0] value);
            if (idx == CFG_SERIAL_LENGTH)
                serial_length = value;
            else
                map_count = value;
        endfunction

        function void push(kind_t k, logic [7:0] d, logic [6:0] a);
            out_item_t r;
            r.kind = k;
            r.data_byte = d;
            r.device_address = a;
            r.boot_enable = 1'b0;
            r.last = 1'b0;
            batch.push_back(r);
        endfunction

        function logic [7:0] hex_digit(logic [3:0] v);
            return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h61 + 8'(v) - 8'd10;
        endfunction

        function void do_setup(in_item_t x);
            int  limit;
            bit  found;
            active_req = {x.request_type, x.request_code};
            req_value = x.setup_value;
            req_len = x.setup_length;
            case (active_req)
                REQ_GET_STATUS:
                begin
                    push(K_DATA, 8'h00, 7'h00);
                    push(K_DATA, 8'h00, 7'h00);
                    push(K_COMMIT, 8'h00, 7'h00);
                end
                REQ_SET_ADDRESS:
                begin
                    push(K_SET_ADDR, 8'h00, req_value[6:0]);
                    push(K_COMMIT, 8'h00, 7'h00);
                end
                REQ_GET_DESC:
                begin
                    if (req_value == SERIAL_KEY)
                    begin
                        limit = (serial_length > 16) ? 16 : serial_length;
                        str_pos = 8'd2;
                        str_len = 8'(4 * limit + 2);
                        push(K_DATA, str_len, 7'h00);
                        push(K_DATA, 8'h03, 7'h00);
                        if (req_len < 16'(str_len))
                            str_len = req_len[7:0];
                    end
                    else
                    begin
                        limit = (map_count > 16) ? 16 : map_count;
                        found = 1'b0;
                        for (int i = 0; i < limit && !found; i++)
                        begin
                            if (map_key[i] == req_value)
                            begin
                                cursor = map_first[i];
                                rom_stop = map_end[i];
                                found = 1'b1;
                            end
                        end
                        if (!found)
                        begin
                            push(K_STALL, 8'h00, 7'h00);
                            active_req = REQ_NONE;
                        end
                        else if (16'(10'(rom_stop - cursor)) > req_len)
                            rom_stop = cursor + req_len[9:0];
                    end
                end
                REQ_SET_CONFIG:
                begin
                    push(K_CONFIG, 8'h00, 7'h00);
                    push(K_COMMIT, 8'h00, 7'h00);
                end
                REQ_SET_LINE:
                    ;
                REQ_GET_LINE:
                begin
                    push(K_DATA, rate[7:0], 7'h00);
                    push(K_DATA, rate[15:8], 7'h00);
                    push(K_DATA, rate[23:16], 7'h00);
                    push(K_DATA, rate[31:24], 7'h00);
                    push(K_DATA, 8'h00, 7'h00);
                    push(K_DATA, 8'h00, 7'h00);
                    push(K_DATA, 8'h08, 7'h00);
                    push(K_COMMIT, 8'h00, 7'h00);
                end
                REQ_SET_CTRL:
                    push(K_COMMIT, 8'h00, 7'h00);
                REQ_BOOT:
                    push(K_BOOT, 8'h00, 7'h00);
                default:
                begin
                    push(K_STALL, 8'h00, 7'h00);
                    active_req = REQ_NONE;
                end
            endcase
        endfunction

        function void do_in_ready();
            int         pos;
            int         left;
            logic [7:0] p2;
            logic [7:0] v;
            if (active_req == REQ_NONE)
                return;
            case (active_req)
                REQ_GET_DESC:
                begin
                    if (req_value == SERIAL_KEY)
                    begin
                        pos = str_pos;
                        left = 32 - (pos % 32);
                        while (pos < str_len && left > 0)
                        begin
                            p2 = 8'(pos - 2);
                            if (p2[0])
                                push(K_DATA, 8'h00, 7'h00);
                            else
                            begin
                                v = serial[p2[7:2]];
                                push(K_DATA, hex_digit(p2[1] ? v[3:0] : v[7:4]), 7'h00);
                            end
                            pos++;
                            left--;
                        end
                        str_pos = 8'(pos);
                    end
                    else
                    begin
                        left = 32;
                        while (cursor != rom_stop && left > 0)
                        begin
                            push(K_DATA, rom[cursor], 7'h00);
                            cursor = cursor + 10'd1;
                            left--;
                        end
                    end
                    if (left > 0)
                        active_req = REQ_NONE;
                    push(K_COMMIT, 8'h00, 7'h00);
                end
                REQ_SET_ADDRESS:
                begin
                    push(K_ADDR_EN, 8'h00, 7'h00);
                    active_req = REQ_NONE;
                end
                REQ_SET_LINE:
                    ;
                default:
                    active_req = REQ_NONE;
            endcase
        endfunction

        function void note_input(in_item_t x);
            batch.delete();
            case (opcode_t'(x.opcode))
                OP_SETUP:
                    do_setup(x);
                OP_IN_READY:
                    do_in_ready();
                OP_OUT_DATA:
                begin
                    if (active_req == REQ_SET_LINE)
                    begin
                        rate = x.out_rate;
                        if (rate == BOOT_RATE)
                            push(K_BOOT, 8'h00, 7'h00);
                        boot = (rate == DEFAULT_RATE);
                        push(K_OUT_ACK, 8'h00, 7'h00);
                        active_req = REQ_NONE;
                        push(K_COMMIT, 8'h00, 7'h00);
                    end
                    else
                        push(K_OUT_ACK, 8'h00, 7'h00);
                end
                OP_BUS_RESET:
                    active_req = REQ_NONE;
                OP_LOAD_ROM:
                    rom[x.load_address] = x.load_byte;
                OP_LOAD_MAP:
                begin
                    if (x.load_address < 16)
                    begin
                        map_key[x.load_address] = x.map_key;
                        map_first[x.load_address] = x.map_first;
                        map_end[x.load_address] = x.map_end;
                    end
                end
                OP_LOAD_SERIAL:
                begin
                    if (x.load_address < 16)
                        serial[x.load_address] = x.load_byte;
                end
                default:
                    ;
            endcase
            for (int i = 0; i < batch.size(); i++)
            begin
                batch[i].boot_enable = boot;
                batch[i].last = (i == batch.size() - 1);
                expected_q.push_back(batch[i]);
            end
        endfunction

        function void check_result(out_item_t r);
            out_item_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result kind=%0d data_byte=%0h", r.kind, r.data_byte);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (r.kind !== e.kind)
            begin
                $error("kind: expected %0d, actual %0d", e.kind, r.kind);
                errors++;
            end
            if (r.data_byte !== e.data_byte)
            begin
                $error("data_byte: expected %0h, actual %0h", e.data_byte, r.data_byte);
                errors++;
            end
            if (r.device_address !== e.device_address)
            begin
                $error("device_address: expected %0h, actual %0h",
                       e.device_address, r.device_address);
                errors++;
            end
            if (r.boot_enable !== e.boot_enable)
            begin
                $error("boot_enable: expected %0b, actual %0b", e.boot_enable, r.boot_enable);
                errors++;
            end
            if (r.last !== e.last)
            begin
                $error("last: expected %0b, actual %0b", e.last, r.last);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [4:0] cfg_data;

    endpoint_scoreboard sb = new();
    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 0;
    int stall_window = 0;
    int cycles = 0;

    usb_control_endpoint_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("usb_control_endpoint_engine: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
        stall_window++;
        if (stall_window >= 200)
        begin
            stall_window = 0;
            stall_mode = $urandom_range(2);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (stall_mode == 1)
            out_ready <= $urandom_range(1);
        else if (stall_mode == 2 && $urandom_range(15) == 0)
        begin
            stall_left = $urandom_range(1, 20);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    function automatic in_item_t make_event(opcode_t op);
        in_item_t     x;
        logic [159:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        x = raw[$bits(in_item_t)-1:0];
        x.opcode = op;
        return x;
    endfunction

    function automatic in_item_t make_setup(logic [15:0] req, logic [15:0] value,
                                            logic [15:0] req_len);
        in_item_t x;
        x = make_event(OP_SETUP);
        {x.request_type, x.request_code} = req;
        x.setup_value = value;
        x.setup_length = req_len;
        return x;
    endfunction

    function automatic in_item_t make_load(opcode_t op, int addr, logic [7:0] b);
        in_item_t x;
        x = make_event(op);
        x.load_address = 10'(addr);
        x.load_byte = b;
        return x;
    endfunction

    function automatic in_item_t make_map(int slot, logic [15:0] key, logic [9:0] first,
                                          logic [9:0] stop);
        in_item_t x;
        x = make_event(OP_LOAD_MAP);
        x.load_address = 10'(slot);
        x.map_key = key;
        x.map_first = first;
        x.map_end = stop;
        return x;
    endfunction

    function automatic in_item_t make_out(logic [31:0] r);
        in_item_t x;
        x = make_event(OP_OUT_DATA);
        x.out_rate = r;
        return x;
    endfunction

    function automatic logic [15:0] pick_key();
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        return {8'($urandom_range(1, 3)), 8'($urandom_range(0, 3))};
    endfunction

    task automatic send_event(input in_item_t x);
        int gap;
        in_valid <= 1'b1;
        in_data <= x;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(x);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_config(input logic [4:0] serial_len, input logic [4:0] entries);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SERIAL_LENGTH;
        cfg_data <= serial_len;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.configure(CFG_SERIAL_LENGTH, serial_len);
        cfg_index <= CFG_MAP_COUNT;
        cfg_data <= entries;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.configure(CFG_MAP_COUNT, entries);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_step();
        int          pick;
        logic [15:0] req;
        logic [15:0] value;
        logic [15:0] req_len;
        logic [9:0]  first;
        pick = $urandom_range(99);
        if ((sb.active_req == REQ_GET_DESC || sb.active_req == REQ_SET_ADDRESS) && pick < 80)
            send_event(make_event(OP_IN_READY));
        else if (sb.active_req == REQ_SET_LINE && pick < 75)
        begin
            case ($urandom_range(2))
                0: send_event(make_out(DEFAULT_RATE));
                1: send_event(make_out(BOOT_RATE));
                default: send_event(make_out($urandom));
            endcase
        end
        else if (pick < 70)
        begin
            case ($urandom_range(11))
                0: req = REQ_GET_STATUS;
                1: req = REQ_SET_ADDRESS;
                2, 3, 4: req = REQ_GET_DESC;
                5: req = REQ_SET_CONFIG;
                6, 7: req = REQ_SET_LINE;
                8: req = REQ_GET_LINE;
                9: req = REQ_SET_CTRL;
                10: req = REQ_BOOT;
                default: req = 16'($urandom);
            endcase
            case ($urandom_range(9))
                0, 1, 2, 3: value = SERIAL_KEY;
                4: value = 16'($urandom);
                default: value = sb.map_key[$urandom_range(15)];
            endcase
            case ($urandom_range(5))
                0: req_len = 16'hFFFF;
                1: req_len = 16'($urandom);
                default: req_len = 16'($urandom_range(0, 80));
            endcase
            send_event(make_setup(req, value, req_len));
        end
        else
        begin
            first = 10'($urandom_range(15));
            case ($urandom_range(9))
                0: send_event(make_load(OP_LOAD_ROM, $urandom_range(1023), 8'($urandom)));
                1:
                begin
                    if ($urandom_range(4) == 0)
                        send_event(make_map($urandom_range(20), pick_key(),
                                            10'(1016 + $urandom_range(7)), first));
                    else
                        send_event(make_map($urandom_range(20), pick_key(), first,
                                            first + 10'($urandom_range(0, 32))));
                end
                2: send_event(make_load(OP_LOAD_SERIAL, $urandom_range(20), 8'($urandom)));
                3: send_event(make_event(OP_BUS_RESET));
                4: send_event(make_out($urandom));
                5: send_event(make_event(OP_UNUSED));
                default: send_event(make_event(OP_IN_READY));
            endcase
        end
    endtask

    initial
    begin
        logic [4:0] phase_serial[5];
        logic [4:0] phase_map[5];
        logic [9:0] first;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        out_ready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SERIAL_LENGTH;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Descriptors live in the first 48 bytes and in the last 8, which
        // lets an entry wrap around the top of the store.
        for (int a = 0; a < 48; a++)
            send_event(make_load(OP_LOAD_ROM, a, 8'($urandom)));
        for (int a = 1016; a < 1024; a++)
            send_event(make_load(OP_LOAD_ROM, a, 8'($urandom)));
        for (int s = 0; s < 16; s++)
            send_event(make_load(OP_LOAD_SERIAL, s, 8'($urandom)));
        send_event(make_map(0, 16'h0100, 10'd0, 10'd32));
        send_event(make_map(1, 16'h0200, 10'd1016, 10'd8));
        for (int s = 2; s < 16; s++)
        begin
            first = 10'($urandom_range(15));
            send_event(make_map(s, pick_key(), first, first + 10'($urandom_range(0, 32))));
        end
        drain();
        write_config(5'd16, 5'd16);

        send_event(make_event(OP_IN_READY));
        send_event(make_out(32'hFFFFFFFF));
        send_event(make_setup(REQ_GET_STATUS, 16'h0000, 16'h0002));
        send_event(make_setup(REQ_SET_ADDRESS, 16'hFFFF, 16'h0000));
        send_event(make_event(OP_IN_READY));
        send_event(make_setup(REQ_GET_DESC, SERIAL_KEY, 16'hFFFF));
        repeat (3) send_event(make_event(OP_IN_READY));
        send_event(make_setup(REQ_GET_DESC, SERIAL_KEY, 16'h0001));
        send_event(make_event(OP_IN_READY));
        send_event(make_setup(REQ_GET_DESC, 16'h0100, 16'hFFFF));
        repeat (2) send_event(make_event(OP_IN_READY));
        send_event(make_setup(REQ_GET_DESC, 16'h0200, 16'h0005));
        send_event(make_event(OP_IN_READY));
        send_event(make_setup(REQ_GET_DESC, 16'hDEAD, 16'h0040));
        send_event(make_setup(REQ_GET_DESC, 16'h0100, 16'h0000));
        send_event(make_event(OP_BUS_RESET));
        send_event(make_event(OP_IN_READY));
        send_event(make_setup(REQ_SET_CONFIG, 16'h0001, 16'h0000));
        send_event(make_setup(REQ_GET_LINE, 16'h0000, 16'h0007));
        send_event(make_setup(REQ_SET_LINE, 16'h0000, 16'h0007));
        send_event(make_out(BOOT_RATE));
        send_event(make_setup(REQ_SET_LINE, 16'h0000, 16'h0007));
        send_event(make_out(DEFAULT_RATE));
        send_event(make_setup(REQ_SET_CTRL, 16'h0003, 16'h0000));
        send_event(make_setup(REQ_BOOT, 16'h0000, 16'h0000));
        send_event(make_setup(16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_event(make_event(OP_UNUSED));
        send_event(make_map(1023, 16'h0100, 10'd0, 10'd0));
        send_event(make_load(OP_LOAD_SERIAL, 1023, 8'hFF));
        drain();

        phase_serial = '{5'd16, 5'd0, 5'd31, 5'd7, 5'd1};
        phase_map = '{5'd16, 5'd0, 5'd31, 5'd3, 5'd9};
        for (int p = 0; p < 5; p++)
        begin
            write_config(phase_serial[p], phase_map[p]);
            for (int n = 0; n < 10; n++)
                random_step();
            drain();
        end

        if (sb.errors == 0)
            $display("usb_control_endpoint_engine: match");
        else
            $display("usb_control_endpoint_engine: mismatch");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/usbce_pkg.sv
rtl/core/usbce_ram.sv
rtl/core/usb_control_endpoint_engine.sv
test/usb_control_endpoint_engine_tb.sv
